>>> rtl/mbrp_pkg.sv
// Shared types and constants of the boot sector partition table parser.
`timescale 1ns / 1ps

package mbrp_pkg;

    // Record geometry
    localparam int ENTRY_COUNT  = 4;
    localparam int ENTRY_IW     = 2;
    localparam int SLOT_CW      = 3;
    localparam int RECORD_BYTES = 512;
    localparam int POS_W        = 10;

    // Byte offsets inside the sector
    localparam logic [POS_W-1:0] OFS_DISK    = 10'd440;
    localparam logic [POS_W-1:0] OFS_PROTECT = 10'd444;
    localparam logic [POS_W-1:0] OFS_TABLE   = 10'h1be;
    localparam logic [POS_W-1:0] OFS_SIG     = 10'h1fe;
    localparam logic [POS_W-1:0] ENTRY_BYTES = 10'd16;

    // Field values
    localparam logic [15:0] SIG_VALUE       = 16'hAA55;
    localparam logic [15:0] PROTECT_MAGIC   = 16'h5A5A;
    localparam logic [7:0]  BOOT_RSVD_MASK  = 8'h7f;
    localparam logic [7:0]  TYPE_EMPTY      = 8'h00;
    localparam logic [7:0]  TYPE_PROTECTIVE = 8'hee;

    // Flag bit positions
    localparam int FLAG_BOOT     = 4;
    localparam int FLAG_PRIMARY  = 3;
    localparam int FLAG_EXTENDED = 2;
    localparam int FLAG_LOGICAL  = 1;
    localparam int FLAG_HIDDEN   = 0;

    // Result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SECTOR  = 1'b1;
    localparam logic [15:0] SECTOR_BYTES_RESET = 16'd512;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_sector;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  slot;
        logic [7:0]  type_code;
        logic [4:0]  flags;
        logic [32:0] first_lba;
        logic [31:0] sector_count;
        logic [49:0] first_byte_addr;
        logic [49:0] last_byte_addr;
        logic [31:0] disk_id;
        logic        copy_protected;
        logic        table_valid;
        logic        last_result;
    } result_t;

    // One classified table entry
    typedef struct packed {
        logic        nz;
        logic [7:0]  type_code;
        logic [4:0]  flags;
        logic [31:0] start;
        logic [31:0] count;
    } rec_entry_t;

    // One finished sector, handed from front to back
    typedef struct packed {
        rec_entry_t [ENTRY_COUNT-1:0] entry;
        logic [31:0]                  disk_id;
        logic                         copy_protected;
        logic                         table_valid;
    } sector_rec_t;

endpackage

>>> rtl/mbr_partition_table_parser.sv
// Top level of the boot sector partition table parser.
//
//   channel   direction  handshake                 payload
//   item      in         push / full               in_item_t (data_byte, end_of_sector)
//   result    out        empty / pop               result_t (nz entries, then summary)
//   config    in         cfg_write                 cfg_index, cfg_data
//
// One byte is taken every cycle while full is low. A finished sector is classified
// in the cycle after its last byte and queued once the sector queue has room; the
// back end then walks it slot by slot, then the summary, and each result passes two
// more stages (sum, multiply) before it reaches the output queue. full rises only
// while a classified sector waits on a full sector queue. Reset is asynchronous:
// sector_bytes returns to 512 and base_sector to 0; no clearing pass runs.
`timescale 1ns / 1ps

module mbr_partition_table_parser
    import mbrp_pkg::*;
#(
    parameter int REC_DEPTH = 2,
    parameter int OUT_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_item_t             item,
    input  logic                 push,
    output logic                 full,
    output result_t              result,
    output logic                 empty,
    input  logic                 pop,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
    localparam int REC_CW = $clog2(REC_DEPTH + 1);

    logic [15:0]        sector_bytes_reg, sector_bytes_next;
    logic [31:0]        base_sector_reg, base_sector_next;
    logic               master;
    logic               rec_push, rec_full, rec_empty, rec_pop;
    sector_rec_t        rec_wr, rec_rd;
    logic [$bits(sector_rec_t)-1:0] rec_rd_bits;
    logic [REC_CW-1:0]  rec_count;
    logic               out_push, out_full;
    result_t            out_wr;
    logic [$bits(result_t)-1:0] out_rd_bits;
    logic [OUT_CW-1:0]  out_count;

    // Write configuration registers
    always_comb
    begin
        sector_bytes_next = sector_bytes_reg;
        base_sector_next  = base_sector_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SECTOR_BYTES: sector_bytes_next = cfg_data[15:0];
                CFG_BASE_SECTOR:  base_sector_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_bytes_reg <= SECTOR_BYTES_RESET;
            base_sector_reg  <= '0;
        end
        else
        begin
            sector_bytes_reg <= sector_bytes_next;
            base_sector_reg  <= base_sector_next;
        end
    end

    assign master = (base_sector_reg == 32'd0);

    mbrp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .master   (master),
        .rec_push (rec_push),
        .rec_data (rec_wr),
        .rec_full (rec_full)
    );

    mbrp_fifo #(
        .WIDTH ($bits(sector_rec_t)),
        .DEPTH (REC_DEPTH)
    ) u_rec_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rec_push),
        .wr_data (rec_wr),
        .full    (rec_full),
        .pop     (rec_pop),
        .rd_data (rec_rd_bits),
        .empty   (rec_empty),
        .count   (rec_count)
    );

    assign rec_rd = sector_rec_t'(rec_rd_bits);

    mbrp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sector_bytes (sector_bytes_reg),
        .base_sector  (base_sector_reg),
        .rec_data     (rec_rd),
        .rec_empty    (rec_empty),
        .rec_pop      (rec_pop),
        .out_count    (out_count),
        .out_full     (out_full),
        .out_push     (out_push),
        .out_data     (out_wr)
    );

    mbrp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_wr),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_rd_bits),
        .empty   (empty),
        .count   (out_count)
    );

    assign result = result_t'(out_rd_bits);

    a_rec_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count <= REC_CW'(REC_DEPTH))
        else $error("sector queue count out of range");

    a_full_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> rec_full)
        else $error("input stalled while the sector queue had room");

    a_result_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind == KIND_SUMMARY) == result.last_result)
        else $error("summary marker disagrees with result kind");

endmodule

>>> rtl/mbrp_fifo.sv
// Small first-word-fall-through queue in flip-flops.
`timescale 1ns / 1ps

module mbrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok && !pop_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok && !push_ok |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on pop");

endmodule

>>> rtl/mbrp_front.sv
// Front end: captures sector bytes and classifies the finished table.
`timescale 1ns / 1ps

module mbrp_front
    import mbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    item,
    input  logic        push,
    output logic        full,
    input  logic        master,
    output logic        rec_push,
    output sector_rec_t rec_data,
    input  logic        rec_full
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] seen_reg, seen_next;
    logic             pend_reg, pend_next;
    logic             accept;
    logic             in_record;
    logic [POS_W-1:0] rel_full;
    logic [5:0]       rel;

    logic [7:0]  boot_reg  [ENTRY_COUNT];
    logic [7:0]  type_reg  [ENTRY_COUNT];
    logic [31:0] start_reg [ENTRY_COUNT];
    logic [31:0] count_reg [ENTRY_COUNT];
    logic [31:0] disk_reg;
    logic [15:0] prot_reg;
    logic [15:0] sig_reg;

    logic [7:0]  boot_m  [ENTRY_COUNT];
    logic [7:0]  type_m  [ENTRY_COUNT];
    logic [31:0] start_m [ENTRY_COUNT];
    logic [31:0] count_m [ENTRY_COUNT];
    logic [31:0] disk_m;
    logic [15:0] prot_m;
    logic [15:0] sig_m;

    function automatic logic byte_seen(input logic [POS_W-1:0] ofs,
                                       input logic [POS_W-1:0] n);
        return ofs < n;
    endfunction

    function automatic logic type_is_ext(input logic [7:0] t);
        return t inside {8'h05, 8'h0f, 8'h15, 8'h1f, 8'h85};
    endfunction

    function automatic logic type_is_hid(input logic [7:0] t);
        return t inside {8'h14, 8'h15, 8'h16, 8'h17, 8'h1b, 8'h1c, 8'h1e, 8'h1f};
    endfunction

    assign full      = pend_reg && rec_full;
    assign accept    = push && !full;
    assign in_record = pos_reg < POS_W'(RECORD_BYTES);
    assign rel_full  = pos_reg - OFS_TABLE;
    assign rel       = rel_full[5:0];
    assign rec_push  = pend_reg && !rec_full;

    // Count bytes; latch the received length on the last byte
    always_comb
    begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        pend_next = pend_reg;
        if (rec_push)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            if (in_record)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (item.end_of_sector)
            begin
                seen_next = in_record ? pos_reg + 1'b1 : pos_reg;
                pos_next  = '0;
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seen_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            pend_reg <= pend_next;
        end
    end

    // Capture the fields of interest; early offsets of the next sector touch none
    always_ff @(posedge clk)
    begin
        if (accept && in_record)
        begin
            if (pos_reg inside {[OFS_DISK:OFS_DISK + 10'd3]})
            begin
                disk_reg[{pos_reg[1:0], 3'b000} +: 8] <= item.data_byte;
            end
            else if (pos_reg inside {[OFS_PROTECT:OFS_PROTECT + 10'd1]})
            begin
                prot_reg[{pos_reg[0], 3'b000} +: 8] <= item.data_byte;
            end
            else if (pos_reg inside {[OFS_TABLE:OFS_SIG - 10'd1]})
            begin
                case (rel[3:0])
                    4'd0:
                    begin
                        boot_reg[rel[5:4]] <= item.data_byte;
                    end
                    4'd4:
                    begin
                        type_reg[rel[5:4]] <= item.data_byte;
                    end
                    4'd8, 4'd9, 4'd10, 4'd11:
                    begin
                        start_reg[rel[5:4]][{rel[1:0], 3'b000} +: 8] <= item.data_byte;
                    end
                    4'd12, 4'd13, 4'd14, 4'd15:
                    begin
                        count_reg[rel[5:4]][{rel[1:0], 3'b000} +: 8] <= item.data_byte;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (pos_reg inside {[OFS_SIG:OFS_SIG + 10'd1]})
            begin
                sig_reg[{pos_reg[0], 3'b000} +: 8] <= item.data_byte;
            end
        end
    end

    // Mask bytes beyond the received length to zero
    always_comb
    begin
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            boot_m[i] = byte_seen(OFS_TABLE + POS_W'(16 * i), seen_reg) ? boot_reg[i] : '0;
            type_m[i] = byte_seen(OFS_TABLE + POS_W'(16 * i + 4), seen_reg) ?
                        type_reg[i] : '0;
            for (int k = 0; k < 4; k++)
            begin
                start_m[i][8*k +: 8] = byte_seen(OFS_TABLE + POS_W'(16 * i + 8 + k), seen_reg) ?
                                       start_reg[i][8*k +: 8] : 8'd0;
                count_m[i][8*k +: 8] = byte_seen(OFS_TABLE + POS_W'(16 * i + 12 + k), seen_reg) ?
                                       count_reg[i][8*k +: 8] : 8'd0;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            disk_m[8*k +: 8] = byte_seen(OFS_DISK + POS_W'(k), seen_reg) ?
                               disk_reg[8*k +: 8] : 8'd0;
        end
        for (int k = 0; k < 2; k++)
        begin
            prot_m[8*k +: 8] = byte_seen(OFS_PROTECT + POS_W'(k), seen_reg) ?
                               prot_reg[8*k +: 8] : 8'd0;
            sig_m[8*k +: 8]  = byte_seen(OFS_SIG + POS_W'(k), seen_reg) ?
                               sig_reg[8*k +: 8] : 8'd0;
        end
    end

    // Classify entries and check the table rules
    always_comb
    begin
        logic boots_ok;
        logic any_real;
        logic ext;
        boots_ok = 1'b1;
        any_real = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            ext = type_is_ext(type_m[i]);
            if ((boot_m[i] & BOOT_RSVD_MASK) != 8'd0)
            begin
                boots_ok = 1'b0;
            end
            if (type_m[i] != TYPE_EMPTY && type_m[i] != TYPE_PROTECTIVE)
            begin
                any_real = 1'b1;
            end
            rec_data.entry[i].nz                       = (count_m[i] != 32'd0);
            rec_data.entry[i].type_code                = type_m[i];
            rec_data.entry[i].start                    = start_m[i];
            rec_data.entry[i].count                    = count_m[i];
            rec_data.entry[i].flags[FLAG_BOOT]         = boot_m[i][7];
            rec_data.entry[i].flags[FLAG_PRIMARY]      = master;
            rec_data.entry[i].flags[FLAG_EXTENDED]     = ext;
            rec_data.entry[i].flags[FLAG_LOGICAL]      = !master && !ext;
            rec_data.entry[i].flags[FLAG_HIDDEN]       = type_is_hid(type_m[i]);
        end
        rec_data.disk_id        = master ? disk_m : 32'd0;
        rec_data.copy_protected = master && (prot_m == PROTECT_MAGIC);
        rec_data.table_valid    = (seen_reg == POS_W'(RECORD_BYTES)) &&
                                  (sig_m == SIG_VALUE) && boots_ok && any_real;
    end

    a_last_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_sector |=> pend_reg && pos_reg == '0)
        else $error("last byte did not queue a finished sector");

    a_full_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> pend_reg && !rec_push)
        else $error("input stalled without a waiting sector");

    a_long_sector_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_record && !item.end_of_sector |=> pos_reg == POS_W'(RECORD_BYTES))
        else $error("byte position moved past the record end");

endmodule

>>> rtl/mbrp_back.sv
// Back end: walks a finished sector and computes addresses for each result.
`timescale 1ns / 1ps

module mbrp_back
    import mbrp_pkg::*;
#(
    parameter int OUT_DEPTH = 4,
    localparam int CW = $clog2(OUT_DEPTH + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] sector_bytes,
    input  logic [31:0] base_sector,
    input  sector_rec_t rec_data,
    input  logic        rec_empty,
    output logic        rec_pop,
    input  logic [CW-1:0] out_count,
    input  logic        out_full,
    output logic        out_push,
    output result_t     out_data
);

    logic [SLOT_CW-1:0] slot_reg, slot_next;
    logic               s1_valid_reg, s1_valid_next;
    result_t            s1_res_reg, s1_res_next;
    logic [33:0]        s1_sum_reg, s1_sum_next;
    logic               s2_valid_reg;
    result_t            s2_res_reg, s2_res_next;
    logic [CW:0]        inflight;
    logic               credit_ok;
    logic               step;
    logic               at_summary;
    rec_entry_t         cur;
    logic [48:0]        prod_start;
    logic [49:0]        prod_end;

    // Reserve output room for everything in flight
    assign inflight   = {1'b0, out_count} + (CW + 1)'(s1_valid_reg) + (CW + 1)'(s2_valid_reg);
    assign credit_ok  = inflight < (CW + 1)'(OUT_DEPTH);
    assign step       = !rec_empty && credit_ok;
    assign at_summary = (slot_reg == SLOT_CW'(ENTRY_COUNT));
    assign cur        = rec_data.entry[slot_reg[ENTRY_IW-1:0]];
    assign rec_pop    = step && at_summary;

    // Pick the next result of the head sector
    always_comb
    begin
        slot_next     = slot_reg;
        s1_valid_next = 1'b0;
        s1_res_next   = '0;
        s1_sum_next   = '0;
        s1_res_next.disk_id        = rec_data.disk_id;
        s1_res_next.copy_protected = rec_data.copy_protected;
        s1_res_next.table_valid    = rec_data.table_valid;
        if (at_summary)
        begin
            s1_res_next.kind         = KIND_SUMMARY;
            s1_res_next.first_lba    = {1'b0, base_sector};
            s1_res_next.sector_count = 32'd1;
            s1_res_next.last_result  = 1'b1;
            s1_sum_next              = {2'b00, base_sector} + 34'd1;
        end
        else
        begin
            s1_res_next.kind         = KIND_ENTRY;
            s1_res_next.slot         = slot_reg[ENTRY_IW-1:0];
            s1_res_next.type_code    = cur.type_code;
            s1_res_next.flags        = cur.flags;
            s1_res_next.first_lba    = {1'b0, cur.start} + {1'b0, base_sector};
            s1_res_next.sector_count = cur.count;
            s1_sum_next              = {2'b00, cur.start} + {2'b00, base_sector} +
                                       {2'b00, cur.count};
        end
        if (step)
        begin
            slot_next     = at_summary ? '0 : slot_reg + 1'b1;
            s1_valid_next = at_summary || cur.nz;
        end
    end

    // Multiply by the sector size
    assign prod_start = {16'd0, s1_res_reg.first_lba} * {33'd0, sector_bytes};
    assign prod_end   = {16'd0, s1_sum_reg} * {34'd0, sector_bytes};

    // Insert the products into the second stage
    always_comb
    begin
        s2_res_next                 = s1_res_reg;
        s2_res_next.first_byte_addr = {1'b0, prod_start};
        s2_res_next.last_byte_addr  = prod_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg     <= slot_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg <= s1_res_next;
        s1_sum_reg <= s1_sum_next;
        s2_res_reg <= s2_res_next;
    end

    // Drop one from the end product and push
    always_comb
    begin
        out_data                = s2_res_reg;
        out_data.last_byte_addr = s2_res_reg.last_byte_addr - 50'd1;
    end
    assign out_push = s2_valid_reg;

    a_room_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !out_full)
        else $error("result pushed without output room");

    a_summary_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |=> s1_valid_reg && s1_res_reg.last_result && slot_reg == '0)
        else $error("sector retired without a summary");

    a_pop_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> !rec_empty)
        else $error("sector retired from an empty queue");

endmodule

>>> bench/mbr_partition_table_parser_tb.sv
// Self-checking testbench for the boot sector partition table parser.
`timescale 1ns / 1ps

module mbr_partition_table_parser_tb;
    import mbrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 200;
    localparam int PRINT_CAP      = 200;
    localparam int DIRECT_SECTORS = 10;
    localparam int CONFIG_PHASES  = 6;
    localparam int PHASE_SECTORS  = 2;
    localparam int PRESS_SECTORS  = 12;
    localparam int MAX_SECTOR_LEN = 10;

    // Partition type codes that drive the extended and hidden flags
    localparam logic [7:0] TYPE_EXT_CHS     = 8'h05;
    localparam logic [7:0] TYPE_EXT_LBA     = 8'h0f;
    localparam logic [7:0] TYPE_HID_EXT_CHS = 8'h15;
    localparam logic [7:0] TYPE_HID_EXT_LBA = 8'h1f;
    localparam logic [7:0] TYPE_LINUX_EXT   = 8'h85;
    localparam logic [7:0] TYPE_HID_FAT16S  = 8'h14;
    localparam logic [7:0] TYPE_HID_FAT16   = 8'h16;
    localparam logic [7:0] TYPE_HID_NTFS    = 8'h17;
    localparam logic [7:0] TYPE_HID_FAT32   = 8'h1b;
    localparam logic [7:0] TYPE_HID_FAT32X  = 8'h1c;
    localparam logic [7:0] TYPE_HID_FAT16X  = 8'h1e;
    localparam logic [31:0] WORD_ONES       = 32'hffffffff;

    typedef enum int {
        SHAPE_ZERO,
        SHAPE_ONES,
        SHAPE_RANDOM
    } sector_shape_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    in_item_t             item_in = '0;
    logic                 push = 1'b0;
    logic                 full;
    result_t              result_out;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    logic [7:0] sector_buf[$];
    bit         hold_request = 1'b0;
    int         idle_cycles;

    mbr_partition_table_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_in),
        .push      (push),
        .full      (full),
        .result    (result_out),
        .empty     (empty),
        .pop       (pop),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicts the entry and summary results of each sector and checks them in order
    class partition_result_tracker;
        logic [15:0] sector_bytes;
        logic [31:0] base_sector;
        int          byte_pos;
        logic [7:0]  boot_byte[ENTRY_COUNT];
        logic [7:0]  type_byte[ENTRY_COUNT];
        logic [31:0] rel_start[ENTRY_COUNT];
        logic [31:0] sect_count[ENTRY_COUNT];
        logic [31:0] disk_word;
        logic [15:0] protect_word;
        logic [15:0] signature_word;
        result_t     pending_results[$];
        int          errors;

        function new();
            sector_bytes = SECTOR_BYTES_RESET;
            base_sector = '0;
            errors = 0;
            clear_capture();
        endfunction

        function void clear_capture();
            byte_pos = 0;
            disk_word = '0;
            protect_word = '0;
            signature_word = '0;
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                boot_byte[i] = '0;
                type_byte[i] = '0;
                rel_start[i] = '0;
                sect_count[i] = '0;
            end
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_SECTOR_BYTES)
                sector_bytes = data[15:0];
            else if (idx == CFG_BASE_SECTOR)
                base_sector = data;
        endfunction

        function bit type_is_ext(logic [7:0] t);
            return t == TYPE_EXT_CHS || t == TYPE_EXT_LBA || t == TYPE_HID_EXT_CHS ||
                   t == TYPE_HID_EXT_LBA || t == TYPE_LINUX_EXT;
        endfunction

        function bit type_is_hid(logic [7:0] t);
            return t == TYPE_HID_FAT16S || t == TYPE_HID_EXT_CHS || t == TYPE_HID_FAT16 ||
                   t == TYPE_HID_NTFS || t == TYPE_HID_FAT32 || t == TYPE_HID_FAT32X ||
                   t == TYPE_HID_FAT16X || t == TYPE_HID_EXT_LBA;
        endfunction

        // Store one byte at its sector offset
        function void capture(logic [POS_W-1:0] p, logic [7:0] b);
            logic [POS_W-1:0] rel;
            int               idx;
            int               off;
            if (p >= OFS_DISK && p < OFS_DISK + 4)
                disk_word[8*(p - OFS_DISK) +: 8] = b;
            else if (p >= OFS_PROTECT && p < OFS_PROTECT + 2)
                protect_word[8*(p - OFS_PROTECT) +: 8] = b;
            else if (p >= OFS_TABLE && p < OFS_TABLE + ENTRY_BYTES * ENTRY_COUNT)
            begin
                rel = p - OFS_TABLE;
                idx = rel[5:4];
                off = rel[3:0];
                if (off == 0)
                    boot_byte[idx] = b;
                else if (off == 4)
                    type_byte[idx] = b;
                else if (off >= 8 && off < 12)
                    rel_start[idx][8*(off - 8) +: 8] = b;
                else if (off >= 12)
                    sect_count[idx][8*(off - 12) +: 8] = b;
            end
            else if (p >= OFS_SIG && p < OFS_SIG + 2)
                signature_word[8*(p - OFS_SIG) +: 8] = b;
        endfunction

        function result_t make_result(logic kind, logic [1:0] slot, logic [7:0] tc,
                                      logic [4:0] fl, logic [32:0] s, logic [31:0] cnt,
                                      logic [31:0] did, logic cp, logic valid);
            result_t     r;
            logic [63:0] sb64;
            logic [63:0] lo;
            logic [63:0] hi;
            sb64 = {48'd0, sector_bytes};
            lo = {31'd0, s} * sb64;
            hi = ({31'd0, s} + {32'd0, cnt}) * sb64 - 64'd1;
            r.kind = kind;
            r.slot = slot;
            r.type_code = tc;
            r.flags = fl;
            r.first_lba = s;
            r.sector_count = cnt;
            r.first_byte_addr = lo[49:0];
            r.last_byte_addr = hi[49:0];
            r.disk_id = did;
            r.copy_protected = cp;
            r.table_valid = valid;
            r.last_result = (kind == KIND_SUMMARY);
            return r;
        endfunction

        // Advance the capture on an accepted byte; on the last byte queue the results
        function void record_byte(in_item_t it);
            logic        boots_ok;
            logic        any_real;
            logic        valid;
            logic        master;
            logic        cp;
            logic [31:0] did;
            logic [4:0]  fl;
            logic        ext;
            if (byte_pos < RECORD_BYTES)
            begin
                capture(byte_pos[POS_W-1:0], it.data_byte);
                byte_pos++;
            end
            if (!it.end_of_sector)
                return;
            boots_ok = 1'b1;
            any_real = 1'b0;
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                if ((boot_byte[i] & BOOT_RSVD_MASK) != 8'd0)
                    boots_ok = 1'b0;
                if (type_byte[i] != TYPE_EMPTY && type_byte[i] != TYPE_PROTECTIVE)
                    any_real = 1'b1;
            end
            master = (base_sector == 32'd0);
            valid = byte_pos >= RECORD_BYTES && signature_word == SIG_VALUE &&
                    boots_ok && any_real;
            did = master ? disk_word : 32'd0;
            cp = master && protect_word == PROTECT_MAGIC;
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                if (sect_count[i] != 32'd0)
                begin
                    ext = type_is_ext(type_byte[i]);
                    fl = '0;
                    fl[FLAG_BOOT] = boot_byte[i][7];
                    fl[FLAG_PRIMARY] = master;
                    fl[FLAG_EXTENDED] = ext;
                    fl[FLAG_LOGICAL] = !master && !ext;
                    fl[FLAG_HIDDEN] = type_is_hid(type_byte[i]);
                    pending_results.insert(pending_results.size(),
                        make_result(KIND_ENTRY, 2'(i), type_byte[i], fl,
                        {1'b0, rel_start[i]} + {1'b0, base_sector}, sect_count[i],
                        did, cp, valid));
                end
            end
            pending_results.insert(pending_results.size(),
                make_result(KIND_SUMMARY, 2'd0, 8'd0, 5'd0,
                {1'b0, base_sector}, 32'd1, did, cp, valid));
            clear_capture();
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
            if (exp_val !== got_val)
            begin
                errors++;
                // keep the log bounded when the block is badly off
                if (errors <= PRINT_CAP)
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $time, name, exp_val, got_val);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("kind", exp_r.kind, got.kind);
            compare_field("slot", exp_r.slot, got.slot);
            compare_field("type_code", exp_r.type_code, got.type_code);
            compare_field("flags", exp_r.flags, got.flags);
            compare_field("first_lba", exp_r.first_lba, got.first_lba);
            compare_field("sector_count", exp_r.sector_count, got.sector_count);
            compare_field("first_byte_addr", exp_r.first_byte_addr, got.first_byte_addr);
            compare_field("last_byte_addr", exp_r.last_byte_addr, got.last_byte_addr);
            compare_field("disk_id", exp_r.disk_id, got.disk_id);
            compare_field("copy_protected", exp_r.copy_protected, got.copy_protected);
            compare_field("table_valid", exp_r.table_valid, got.table_valid);
            compare_field("last_result", exp_r.last_result, got.last_result);
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

    partition_result_tracker tracker = new();

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Fill sector_buf with a short sector of the given fill pattern
    task automatic build_sector(sector_shape_e shape, int len);
        sector_buf.delete();
        for (int k = 0; k < len; k++)
        begin
            if (shape == SHAPE_ZERO)
                sector_buf.insert(sector_buf.size(), 8'h00);
            else if (shape == SHAPE_ONES)
                sector_buf.insert(sector_buf.size(), 8'hff);
            else
                sector_buf.insert(sector_buf.size(), 8'($urandom));
        end
    endtask

    // Offer each byte of sector_buf, the final one marked last
    task automatic send_sector(bit no_gaps);
        int gap;
        for (int k = 0; k < sector_buf.size(); k++)
        begin
            gap = no_gaps ? 0 : pick_gap();
            repeat (gap)
            begin
                @(negedge clk);
                push = 1'b0;
            end
            @(negedge clk);
            push = 1'b1;
            item_in.data_byte = sector_buf[k];
            item_in.end_of_sector = (k == sector_buf.size() - 1);
            do @(posedge clk); while (full);
            tracker.record_byte(item_in);
        end
    endtask

    task automatic send_shape(sector_shape_e shape);
        build_sector(shape, $urandom_range(1, MAX_SECTOR_LEN));
        send_sector($urandom_range(0, 3) == 0);
    endtask

    task automatic send_random_sector();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            send_shape(SHAPE_ZERO);
        else if (r < 40)
            send_shape(SHAPE_ONES);
        else
            send_shape(SHAPE_RANDOM);
    endtask

    // Drop push, wait for every expected result, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        tracker.set_config(idx, data);
    endtask

    // Write both registers; upper bits of the sector size word are junk
    task automatic apply_config(logic [15:0] sb, logic [31:0] base);
        write_reg(CFG_SECTOR_BYTES, {16'($urandom), sb});
        write_reg(CFG_BASE_SECTOR, base);
    endtask

    // Result side: pop with random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                pop = 1'b0;
                stall_left--;
            end
            else
                pop = 1'b1;
            @(posedge clk);
            if (pop && !empty)
            begin
                tracker.check_result(result_out);
                stall_left = pick_gap();
            end
        end
    end

    // End the run if no transaction completes for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("mbr_partition_table_parser verification failed");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Short sectors under the reset configuration
        for (int s = 0; s < DIRECT_SECTORS; s++)
            send_random_sector();
        drain();

        // Register extremes first, then random settings
        for (int p = 0; p < CONFIG_PHASES; p++)
        begin
            case (p)
                0: apply_config(16'd1, WORD_ONES);
                1: apply_config(16'hffff, 32'd0);
                2: apply_config(16'd0, 32'd1);
                3: apply_config(SECTOR_BYTES_RESET, 32'd0);
                default: apply_config(16'($urandom_range(1, 65535)),
                                      $urandom_range(0, 1) ? 32'd0 : 32'($urandom));
            endcase
            for (int s = 0; s < PHASE_SECTORS; s++)
                send_random_sector();
            drain();
        end

        // Hold the result side while streaming one-byte sectors to back up the input
        apply_config(16'($urandom_range(1, 65535)), $urandom_range(0, 1) ? 32'd0 : 32'($urandom));
        hold_request = 1'b1;
        for (int s = 0; s < PRESS_SECTORS; s++)
        begin
            build_sector(SHAPE_RANDOM, 1);
            send_sector(1'b1);
        end
        drain();

        if (tracker.errors == 0 && tracker.pending_count() == 0)
            $display("mbr_partition_table_parser verification clean");
        else
            $display("mbr_partition_table_parser verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mbrp_pkg.sv
rtl/mbrp_fifo.sv
rtl/mbrp_front.sv
rtl/mbrp_back.sv
rtl/mbr_partition_table_parser.sv
bench/mbr_partition_table_parser_tb.sv
